@@ hdl/wctt_pkg.sv @@
// Shared types and constants for the client tracking table.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package wctt_pkg;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_NEW      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_READ_BAD = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic [11:0] MIN_HEADER_BYTES = 12'd24;
  localparam logic [1:0]  FT_MANAGEMENT    = 2'd0;
  localparam logic [1:0]  FT_PAYLOAD       = 2'd2;
  localparam logic [3:0]  SUB_ASSOC        = 4'd0;
  localparam logic [3:0]  SUB_REASSOC      = 4'd2;
  localparam logic [3:0]  SUB_PROBE        = 4'd4;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;      // capture the input word
    logic scan_start; // reset the search pointer
    logic scan_step;  // advance the search pointer
    logic rd_scan;    // read the entry at the search pointer
    logic rd_hit;     // read the entry chosen for the result
    logic wr_entry;   // write the updated entry back
    logic clear;      // empty the table
    logic emit;       // drive a result
    logic [2:0] status;
    logic with_entry;
  } wctt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic track;
    logic match;      // registered entry equals client
    logic scan_done;  // pointer reached entry count
    logic full;
    logic read_ok;
  } wctt_stat_t;

endpackage
`default_nettype wire

@@ hdl/wctt_ctrl.sv @@
// Controller state machine of the client tracking table.
// Depends on wctt_pkg; drives the datapath through wctt_cmd_t.
`default_nettype none
module wctt_ctrl
  import wctt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  output wctt_cmd_t       cmd,
  input  wctt_stat_t      stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic       found, found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    found_next = found;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_start = 1'b1;
        unique case (stat.op)
          OP_FRAME: begin
            if (stat.track) state_next = S_READ;
            else begin
              cmd.emit = 1'b1;
              cmd.status = ST_IGNORED;
              state_next = S_IDLE;
            end
          end
          OP_READ: begin
            // The read address is loaded on this edge, so the fetch follows.
            if (stat.read_ok) begin
              state_next = S_FETCH;
            end else begin
              cmd.emit = 1'b1;
              cmd.status = ST_READ_BAD;
              state_next = S_IDLE;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.emit = 1'b1;
            cmd.status = ST_CLEARED;
            state_next = S_IDLE;
          end
          default: begin
            cmd.emit = 1'b1;
            cmd.status = ST_IGNORED;
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (stat.scan_done) begin
          if (stat.full) begin
            cmd.emit = 1'b1;
            cmd.status = ST_FULL;
            state_next = S_IDLE;
          end else begin
            found_next = 1'b0;
            state_next = S_UPD;
          end
        end else begin
          cmd.rd_scan = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          found_next = 1'b1;
          state_next = S_UPD;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = S_READ;
        end
      end
      S_UPD: begin
        cmd.wr_entry = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_hit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        cmd.with_entry = 1'b1;
        if (stat.op == OP_READ) cmd.status = ST_READ_OK;
        else if (found) cmd.status = ST_UPDATED;
        else cmd.status = ST_NEW;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/wctt_dp.sv @@
// Datapath of the client tracking table: input word, entry memory, search
// pointer and result register. Depends on wctt_pkg; commanded by wctt_ctrl.
`default_nettype none
module wctt_dp
  import wctt_pkg::*;
#(
  parameter int MAX_CLIENTS = 64,
  parameter int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1,
  parameter int CNT_W = $clog2(MAX_CLIENTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wctt_cmd_t              cmd,
  output wctt_stat_t             stat,
  input  wire logic [1:0]        op,
  input  wire logic              is_misc,
  input  wire logic [11:0]       frame_length,
  input  wire logic [7:0]        control_low,
  input  wire logic [7:0]        control_high,
  input  wire logic [47:0]       receiver_address,
  input  wire logic [47:0]       transmitter_address,
  input  wire logic [47:0]       third_address,
  input  wire logic signed [7:0] signal_strength,
  input  wire logic [7:0]        channel,
  input  wire logic [5:0]        read_index,
  output logic                   res_valid,
  output logic [2:0]             res_status,
  output logic [5:0]             res_index,
  output logic [47:0]            res_address,
  output logic signed [7:0]      res_strength,
  output logic [7:0]             res_channel,
  output logic [31:0]            res_frames,
  output logic                   res_associated,
  output logic [47:0]            res_access_point,
  output logic [6:0]             res_used
);

  typedef struct packed {
    logic [47:0] address;
    logic [7:0]  strength;
    logic [7:0]  chan;
    logic [31:0] frames;
    logic        associated;
    logic [47:0] access_point;
  } entry_t;

  entry_t mem [MAX_CLIENTS];
  entry_t rd_entry;

  logic [1:0]       in_op;
  logic [47:0]      client, bssid;
  logic [7:0]       in_strength, in_channel;
  logic [5:0]       in_index;
  logic             track, assoc;
  logic [CNT_W-1:0] count, ptr;
  logic [IDX_W-1:0] hit_idx;

  logic       trk_c, asc_c;
  logic [1:0] ftype;
  logic [3:0] fsub;
  logic [47:0] bssid_c;

  always_comb begin
    ftype = control_low[3:2];
    fsub = control_low[7:4];
    trk_c = 1'b0;
    asc_c = 1'b0;
    bssid_c = '0;
    if (ftype == FT_MANAGEMENT) begin
      if (fsub == SUB_PROBE) trk_c = 1'b1;
      else if (fsub == SUB_ASSOC || fsub == SUB_REASSOC) begin
        trk_c = 1'b1;
        asc_c = 1'b1;
        bssid_c = third_address;
      end
    end else if (ftype == FT_PAYLOAD && control_high[0] && !control_high[1]) begin
      trk_c = 1'b1;
      asc_c = 1'b1;
      bssid_c = receiver_address;
    end
    if (is_misc || frame_length < MIN_HEADER_BYTES || transmitter_address[40]) trk_c = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_op <= op;
      client <= transmitter_address;
      bssid <= bssid_c;
      in_strength <= signal_strength;
      in_channel <= channel;
      in_index <= read_index;
      track <= trk_c;
      assoc <= asc_c;
    end
  end

  // The write slot is the hit, or the next free entry on a miss.
  logic [IDX_W-1:0] wr_idx;
  assign wr_idx = stat.scan_done ? count[IDX_W-1:0] : ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr <= '0;
    end else if (cmd.scan_step) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.scan_start) hit_idx <= IDX_W'(in_index);
    else if (cmd.wr_entry) hit_idx <= wr_idx;
  end

  entry_t upd;
  always_comb begin
    if (stat.scan_done) begin
      upd = '0;
      upd.address = client;
    end else begin
      upd = rd_entry;
    end
    upd.strength = in_strength;
    upd.chan = in_channel;
    upd.frames = upd.frames + 32'd1;
    if (assoc && bssid != '0) begin
      upd.associated = 1'b1;
      upd.access_point = bssid;
    end
  end

  logic [IDX_W-1:0] rd_addr;
  assign rd_addr = cmd.rd_scan ? ptr[IDX_W-1:0] : hit_idx;

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) mem[wr_idx] <= upd;
    if (cmd.rd_scan || cmd.rd_hit) rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) count <= '0;
    else if (cmd.wr_entry && stat.scan_done) count <= count + 1'b1;
  end

  assign stat.op = in_op;
  assign stat.track = track;
  assign stat.match = (rd_entry.address == client);
  assign stat.scan_done = (ptr >= count);
  assign stat.full = (count == CNT_W'(MAX_CLIENTS));
  assign stat.read_ok = ({1'b0, in_index} < (7)'(count)) && (32'(in_index) < MAX_CLIENTS);

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= cmd.emit;
    if (cmd.emit) begin
      res_status <= cmd.status;
      res_used <= cmd.clear ? 7'd0 : 7'(count);
      if (cmd.with_entry) begin
        res_index <= 6'(hit_idx);
        res_address <= rd_entry.address;
        res_strength <= rd_entry.strength;
        res_channel <= rd_entry.chan;
        res_frames <= rd_entry.frames;
        res_associated <= rd_entry.associated;
        res_access_point <= rd_entry.access_point;
      end else begin
        res_index <= '0;
        res_address <= '0;
        res_strength <= '0;
        res_channel <= '0;
        res_frames <= '0;
        res_associated <= 1'b0;
        res_access_point <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/wifi_client_tracking_table_core.sv @@
// Top level of the client tracking table: controller plus datapath.
// Depends on wctt_pkg, wctt_ctrl and wctt_dp.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  command  | start / busy       | op .. read_index
//  result   | done (one cycle)   | status .. entries_used
//
// A search reads the entries one at a time over the single read port, one
// compare per memory read, and stops at the first hit; a new entry or a full
// table is found only after every entry is read. A hit or a new entry is
// written back, read again and reported; a good read is read and reported.
// Synchronous reset empties the table at once. Busy is low again while done
// is high. Results cannot be stalled.
`default_nettype none
module wifi_client_tracking_table_core
  import wctt_pkg::*;
#(
  parameter int MAX_CLIENTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        op,
  input  wire logic              is_misc,
  input  wire logic [11:0]       frame_length,
  input  wire logic [7:0]        control_low,
  input  wire logic [7:0]        control_high,
  input  wire logic [47:0]       receiver_address,
  input  wire logic [47:0]       transmitter_address,
  input  wire logic [47:0]       third_address,
  input  wire logic signed [7:0] signal_strength,
  input  wire logic [7:0]        channel,
  input  wire logic [5:0]        read_index,
  output logic                   done,
  output logic [2:0]             status,
  output logic [5:0]             entry_index,
  output logic [47:0]            client_address,
  output logic signed [7:0]      client_strength,
  output logic [7:0]             client_channel,
  output logic [31:0]            client_frames,
  output logic                   client_associated,
  output logic [47:0]            access_point,
  output logic [6:0]             entries_used
);

  wctt_cmd_t  cmd;
  wctt_stat_t stat;
  logic       ctl_busy;

  wctt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(ctl_busy), .cmd(cmd), .stat(stat)
  );

  assign busy = ctl_busy;

  wctt_dp #(.MAX_CLIENTS(MAX_CLIENTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .op(op), .is_misc(is_misc), .frame_length(frame_length),
    .control_low(control_low), .control_high(control_high),
    .receiver_address(receiver_address), .transmitter_address(transmitter_address),
    .third_address(third_address), .signal_strength(signal_strength),
    .channel(channel), .read_index(read_index),
    .res_valid(done), .res_status(status), .res_index(entry_index),
    .res_address(client_address), .res_strength(client_strength),
    .res_channel(client_channel), .res_frames(client_frames),
    .res_associated(client_associated), .res_access_point(access_point),
    .res_used(entries_used)
  );

endmodule
`default_nettype wire

@@ hdl/wctt_checker.sv @@
// Port-level checks on the client tracking table, bound to the top level.
// Depends on wctt_pkg for the status codes.
`default_nettype none
module wctt_port_props
  import wctt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [2:0]  status,
  input wire logic [5:0]  entry_index,
  input wire logic [6:0]  entries_used
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held longer than one cycle");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_CLEARED) |-> entries_used == 7'd0)
    else $error("clear left entries");

  a_new_last: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NEW) |-> {1'b0, entry_index} == entries_used - 7'd1)
    else $error("new entry not appended at the end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");

endmodule

bind wifi_client_tracking_table_core wctt_port_props u_wctt_port_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .entry_index(entry_index), .entries_used(entries_used)
);
`default_nettype wire

@@ sim/wctt_checker.sv @@
// Checker for the client tracking table: watches the command and result channels,
// keeps its own copy of the table and compares every result word field by field.
// Depends on wctt_pkg for the op and status codes.
`default_nettype none
module wctt_checker
  import wctt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  op,
  input  wire logic        is_misc,
  input  wire logic [11:0] frame_length,
  input  wire logic [7:0]  control_low,
  input  wire logic [7:0]  control_high,
  input  wire logic [47:0] receiver_address,
  input  wire logic [47:0] transmitter_address,
  input  wire logic [47:0] third_address,
  input  wire logic [7:0]  signal_strength,
  input  wire logic [7:0]  channel,
  input  wire logic [5:0]  read_index,
  input  wire logic        done,
  input  wire logic [2:0]  status,
  input  wire logic [5:0]  entry_index,
  input  wire logic [47:0] client_address,
  input  wire logic [7:0]  client_strength,
  input  wire logic [7:0]  client_channel,
  input  wire logic [31:0] client_frames,
  input  wire logic        client_associated,
  input  wire logic [47:0] access_point,
  input  wire logic [6:0]  entries_used,
  output int               mismatches,
  output int               pending
);

  localparam int TABLE_DEPTH = 64;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [47:0] address;
    logic [7:0]  strength;
    logic [7:0]  chan;
    logic [31:0] frames;
    logic        associated;
    logic [47:0] bssid;
    logic [6:0]  used;
  } table_word_t;

  logic [47:0] tbl_address [TABLE_DEPTH];
  logic [7:0]  tbl_strength [TABLE_DEPTH];
  logic [7:0]  tbl_channel [TABLE_DEPTH];
  logic [31:0] tbl_frames [TABLE_DEPTH];
  logic        tbl_associated [TABLE_DEPTH];
  logic [47:0] tbl_bssid [TABLE_DEPTH];
  int          tbl_count;

  table_word_t expected_words [$];

  initial begin
    mismatches = 0;
    pending = 0;
    tbl_count = 0;
  end

  function automatic table_word_t table_word(logic [2:0] st, bit with_entry, int idx);
    table_word_t w;
    w = '{status: st, index: '0, address: '0, strength: '0, chan: '0, frames: '0,
          associated: 1'b0, bssid: '0, used: tbl_count[6:0]};
    if (with_entry) begin
      w.index      = idx[5:0];
      w.address    = tbl_address[idx];
      w.strength   = tbl_strength[idx];
      w.chan       = tbl_channel[idx];
      w.frames     = tbl_frames[idx];
      w.associated = tbl_associated[idx];
      w.bssid      = tbl_bssid[idx];
    end
    return w;
  endfunction

  // Applies one accepted frame word to the table copy and returns its result.
  function automatic table_word_t track_frame();
    logic [1:0]  ftype;
    logic [3:0]  fsub;
    logic [47:0] bssid;
    bit          track;
    bit          assoc;
    bit          found;
    int          idx;
    ftype = control_low[3:2];
    fsub  = control_low[7:4];
    bssid = '0;
    track = 0;
    assoc = 0;
    found = 0;
    idx   = 0;
    if (is_misc || frame_length < MIN_HEADER_BYTES) return table_word(ST_IGNORED, 0, 0);
    if (ftype == FT_MANAGEMENT) begin
      if (fsub == SUB_PROBE) begin
        track = 1;
      end else if (fsub == SUB_ASSOC || fsub == SUB_REASSOC) begin
        track = 1;
        assoc = 1;
        bssid = third_address;
      end
    end else if (ftype == FT_PAYLOAD && control_high[1:0] == 2'b01) begin
      track = 1;
      assoc = 1;
      bssid = receiver_address;
    end
    if (!track || transmitter_address[40]) return table_word(ST_IGNORED, 0, 0);
    for (int i = 0; i < tbl_count; i++) begin
      if (!found && tbl_address[i] == transmitter_address) begin
        found = 1;
        idx = i;
      end
    end
    if (!found) begin
      if (tbl_count >= TABLE_DEPTH) return table_word(ST_FULL, 0, 0);
      idx = tbl_count;
      tbl_count++;
      tbl_address[idx]    = transmitter_address;
      tbl_frames[idx]     = '0;
      tbl_associated[idx] = 1'b0;
      tbl_bssid[idx]      = '0;
    end
    tbl_strength[idx] = signal_strength;
    tbl_channel[idx]  = channel;
    tbl_frames[idx]   = tbl_frames[idx] + 32'd1;
    if (assoc && bssid != '0) begin
      tbl_associated[idx] = 1'b1;
      tbl_bssid[idx]      = bssid;
    end
    return table_word(found ? ST_UPDATED : ST_NEW, 1, idx);
  endfunction

  function automatic table_word_t apply_command();
    case (op)
      OP_FRAME: return track_frame();
      OP_READ: begin
        if (read_index < tbl_count) return table_word(ST_READ_OK, 1, read_index);
        return table_word(ST_READ_BAD, 0, 0);
      end
      OP_CLEAR: begin
        tbl_count = 0;
        return table_word(ST_CLEARED, 0, 0);
      end
      default: return table_word(ST_IGNORED, 0, 0);
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    table_word_t w;
    if (rst) begin
      tbl_count = 0;
      expected_words.delete();
    end else begin
      if (start && !busy) expected_words.push_back(apply_command());
      if (done) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result word with none expected, status %0d", status);
        end else begin
          w = expected_words.pop_front();
          compare_field("status", w.status, status);
          compare_field("entry_index", w.index, entry_index);
          compare_field("client_address", w.address, client_address);
          compare_field("client_strength", w.strength, client_strength);
          compare_field("client_channel", w.chan, client_channel);
          compare_field("client_frames", w.frames, client_frames);
          compare_field("client_associated", w.associated, client_associated);
          compare_field("access_point", w.bssid, access_point);
          compare_field("entries_used", w.used, entries_used);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench top for the client tracking table: clock, reset and command stimulus.
// Depends on wctt_pkg, wifi_client_tracking_table_core and wctt_checker.
`default_nettype none
module tb_top;
  import wctt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 540;

  typedef enum int {K_PROBE, K_ASSOC, K_REASSOC, K_DATA} frame_kind_t;

  typedef struct {
    logic [1:0]  op;
    logic        misc;
    logic [11:0] len;
    logic [7:0]  fc_low;
    logic [7:0]  fc_high;
    logic [47:0] addr1;
    logic [47:0] addr2;
    logic [47:0] addr3;
    logic [7:0]  rssi;
    logic [7:0]  chan;
    logic [5:0]  ridx;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = '0;
  logic is_misc = 1'b0;
  logic [11:0] frame_length = '0;
  logic [7:0] control_low = '0;
  logic [7:0] control_high = '0;
  logic [47:0] receiver_address = '0;
  logic [47:0] transmitter_address = '0;
  logic [47:0] third_address = '0;
  logic signed [7:0] signal_strength = '0;
  logic [7:0] channel = '0;
  logic [5:0] read_index = '0;

  logic busy, done, client_associated;
  logic [2:0] status;
  logic [5:0] entry_index;
  logic [47:0] client_address, access_point;
  logic signed [7:0] client_strength;
  logic [7:0] client_channel;
  logic [31:0] client_frames;
  logic [6:0] entries_used;
  int mismatches, pending;
  int cycles = 0;
  logic [47:0] client_pool [12];

  wifi_client_tracking_table_core DUT (.*);

  wctt_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic command_t noise_cmd();
    command_t c;
    c = '{op: 2'($urandom_range(0, 3)), misc: 1'($urandom_range(0, 1)),
          len: 12'($urandom), fc_low: 8'($urandom), fc_high: 8'($urandom),
          addr1: rand_addr(), addr2: rand_addr(), addr3: rand_addr(),
          rssi: 8'($urandom), chan: 8'($urandom), ridx: 6'($urandom)};
    return c;
  endfunction

  function automatic command_t frame_cmd(frame_kind_t kind, logic [47:0] client);
    command_t c;
    c = noise_cmd();
    c.op    = OP_FRAME;
    c.misc  = 1'b0;
    c.len   = 12'($urandom_range(24, 4095));
    c.addr2 = client;
    case (kind)
      K_PROBE:   c.fc_low = {SUB_PROBE, FT_MANAGEMENT, c.fc_low[1:0]};
      K_ASSOC:   c.fc_low = {SUB_ASSOC, FT_MANAGEMENT, c.fc_low[1:0]};
      K_REASSOC: c.fc_low = {SUB_REASSOC, FT_MANAGEMENT, c.fc_low[1:0]};
      default: begin
        c.fc_low  = {c.fc_low[7:4], FT_PAYLOAD, c.fc_low[1:0]};
        c.fc_high = {c.fc_high[7:2], 2'b01};
      end
    endcase
    // A zero BSSID must leave the association untouched.
    if ($urandom_range(0, 5) == 0) begin
      c.addr1 = '0;
      c.addr3 = '0;
    end
    return c;
  endfunction

  function automatic command_t read_cmd(logic [5:0] idx);
    command_t c;
    c = noise_cmd();
    c.op = OP_READ;
    c.ridx = idx;
    return c;
  endfunction

  function automatic command_t clear_cmd();
    command_t c;
    c = noise_cmd();
    c.op = OP_CLEAR;
    return c;
  endfunction

  // Waits a random gap, then holds the word until the block takes it.
  task automatic send(command_t c);
    int gap;
    bit taken;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    op <= c.op;
    is_misc <= c.misc;
    frame_length <= c.len;
    control_low <= c.fc_low;
    control_high <= c.fc_high;
    receiver_address <= c.addr1;
    transmitter_address <= c.addr2;
    third_address <= c.addr3;
    signal_strength <= c.rssi;
    channel <= c.chan;
    read_index <= c.ridx;
    forever begin
      #1 taken = !busy;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic fill_table();
    send(clear_cmd());
    for (int k = 0; k < 68; k++)
      send(frame_cmd(frame_kind_t'($urandom_range(0, 3)), 48'h0200_0000_0000 + k));
    send(read_cmd(6'd63));
    send(read_cmd(6'd0));
  endtask

  initial begin
    command_t c;
    int pick;
    foreach (client_pool[i]) client_pool[i] = rand_addr() & 48'hFEFF_FFFF_FFFF;
    client_pool[0] = '0;
    client_pool[1] = 48'hFEFF_FFFF_FFFF;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(clear_cmd());
    send(read_cmd(6'd0));
    c = frame_cmd(K_PROBE, client_pool[2]); c.misc = 1'b1; send(c);
    c = frame_cmd(K_PROBE, client_pool[2]); c.len = 12'd23; send(c);
    c = frame_cmd(K_PROBE, client_pool[2]); c.len = 12'd24; c.rssi = 8'h80; c.chan = 8'd0;
    send(c);
    c = frame_cmd(K_PROBE, client_pool[2]); c.len = 12'hFFF; c.rssi = 8'h7F;
    c.chan = 8'hFF; send(c);
    c = frame_cmd(K_ASSOC, client_pool[1]); c.addr3 = '0; send(c);
    c = frame_cmd(K_ASSOC, client_pool[1]); c.addr3 = 48'hFFFF_FFFF_FFFF; send(c);
    c = frame_cmd(K_REASSOC, client_pool[1]); c.addr3 = 48'h0000_0000_0001; send(c);
    c = frame_cmd(K_DATA, client_pool[0]); c.addr1 = 48'h1234_5678_9ABC; send(c);
    c = frame_cmd(K_DATA, client_pool[0]); c.fc_high[1:0] = 2'b10; send(c);
    c = frame_cmd(K_DATA, client_pool[0]); c.fc_high[1:0] = 2'b11; send(c);
    c = frame_cmd(K_DATA, client_pool[0]); c.fc_high[1:0] = 2'b00; send(c);
    c = frame_cmd(K_PROBE, client_pool[3]); c.fc_low[3:2] = 2'd1; send(c);
    c = frame_cmd(K_PROBE, client_pool[3]); c.fc_low[3:2] = 2'd3; send(c);
    c = frame_cmd(K_PROBE, client_pool[3]); c.fc_low[7:4] = 4'd8; send(c);
    c = frame_cmd(K_PROBE, 48'hFFFF_FFFF_FFFF); send(c);
    c = noise_cmd(); c.op = 2'd3; send(c);
    send(read_cmd(6'd0));
    send(read_cmd(6'd2));
    send(read_cmd(6'd63));
    send(clear_cmd());
    send(read_cmd(6'd0));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 200 || n == 500) fill_table();
      if (n == 350) begin
        // The last word must not be offered again while the block drains.
        start <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
        c = frame_cmd(frame_kind_t'($urandom_range(0, 3)), client_pool[$urandom_range(0, 11)]);
      else if (pick < 82) c = read_cmd(6'($urandom_range(0, 15)));
      else if (pick < 85) c = read_cmd(6'($urandom));
      else if (pick < 87) c = clear_cmd();
      else c = noise_cmd();
      send(c);
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ wifi_client_tracking_table_core.f @@
hdl/wctt_pkg.sv
hdl/wctt_ctrl.sv
hdl/wctt_dp.sv
hdl/wifi_client_tracking_table_core.sv
hdl/wctt_checker.sv
sim/wctt_checker.sv
sim/tb_top.sv
